FILE: design/dfls_pkg.sv
// ----------------------------------------------------------------------------
// dfls_pkg
// Shared types and constants for the DCO frequency lock stepper.
// ----------------------------------------------------------------------------
package dfls_pkg;

   localparam int CaptureWidth = 16;
   localparam int FreqWidth    = 31;
   localparam int FineWidth    = 8;
   localparam int CoarseWidth  = 3;
   localparam int CountWidth   = 16;
   localparam int RefShift     = 15;  // 32768 Hz reference: multiply by 2^15

   localparam logic [FineWidth-1:0]   FineReset   = 8'h60;
   localparam logic [CoarseWidth-1:0] CoarseReset = 3'd4;
   localparam logic [FineWidth-1:0]   FineMin     = 8'h00;
   localparam logic [FineWidth-1:0]   FineMax     = 8'hFF;
   localparam logic [CoarseWidth-1:0] CoarseMin   = 3'd0;
   localparam logic [CoarseWidth-1:0] CoarseMax   = 3'd7;
   localparam logic [CountWidth-1:0]  CountMax    = 16'hFFFF;
   localparam logic [FreqWidth-1:0]   MinFreqReset = 31'd0;
   localparam logic [FreqWidth-1:0]   MaxFreqReset = 31'h7FFF_FFFF;

   typedef enum logic [0:0] {
      CSR_MIN_FREQUENCY = 1'b0,
      CSR_MAX_FREQUENCY = 1'b1
   } csr_index_type;

   // Oscillator tuning state carried from one measurement to the next.
   typedef struct packed {
      logic [FineWidth-1:0]   fine_code;
      logic [CoarseWidth-1:0] coarse_range;
      logic [CountWidth-1:0]  adjust_count;
   } tune_state_type;

   // Frequency bounds from the register file.
   typedef struct packed {
      logic [FreqWidth-1:0] min_frequency;
      logic [FreqWidth-1:0] max_frequency;
   } bounds_type;

endpackage

FILE: design/dfls_csr.sv
// ----------------------------------------------------------------------------
// dfls_csr
// Register file holding the lower and upper frequency bounds.
// ----------------------------------------------------------------------------
module dfls_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [0:0]                    csr_index,
   input  logic [dfls_pkg::FreqWidth-1:0] csr_data,
   output dfls_pkg::bounds_type          bounds
);

   dfls_pkg::bounds_type bounds_ff;
   dfls_pkg::bounds_type bounds_in;

   always_comb begin
      bounds_in = bounds_ff;
      if (csr_valid) begin
         case (dfls_pkg::csr_index_type'(csr_index))
            dfls_pkg::CSR_MIN_FREQUENCY: bounds_in.min_frequency = csr_data;
            dfls_pkg::CSR_MAX_FREQUENCY: bounds_in.max_frequency = csr_data;
            default:                     bounds_in = bounds_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff.min_frequency <= dfls_pkg::MinFreqReset;
         bounds_ff.max_frequency <= dfls_pkg::MaxFreqReset;
      end else begin
         bounds_ff <= bounds_in;
      end
   end

   assign bounds = bounds_ff;

endmodule

FILE: design/dfls_step.sv
// ----------------------------------------------------------------------------
// dfls_step
// One tuning step: frequency from the capture difference, bound compare,
// and the saturating fine/coarse code step with the step counter.
// ----------------------------------------------------------------------------
module dfls_step (
   input  logic [dfls_pkg::CaptureWidth-1:0] early_count,
   input  logic [dfls_pkg::CaptureWidth-1:0] late_count,
   input  logic                              start_tune,
   input  dfls_pkg::bounds_type              bounds,
   input  dfls_pkg::tune_state_type          state_cur,
   output dfls_pkg::tune_state_type          state_next,
   output logic                              locked,
   output logic [dfls_pkg::FreqWidth-1:0]    measured_frequency
);

   logic [dfls_pkg::CaptureWidth-1:0] diff;
   logic                              step_down;
   logic                              step_up;
   logic [dfls_pkg::CountWidth-1:0]   count_base;

   // The subtraction wraps naturally at 16 bits, matching the timer rollover.
   assign diff               = late_count - early_count;
   assign measured_frequency = {diff, {dfls_pkg::RefShift{1'b0}}};

   assign locked    = (measured_frequency > bounds.min_frequency) &&
                      (measured_frequency < bounds.max_frequency);
   assign step_down = !locked && (measured_frequency > bounds.max_frequency);
   assign step_up   = !locked && !step_down &&
                      (measured_frequency < bounds.min_frequency);

   assign count_base = start_tune ? '0 : state_cur.adjust_count;

   always_comb begin
      state_next              = state_cur;
      state_next.adjust_count = count_base;
      if (step_down) begin
         if (state_cur.fine_code != dfls_pkg::FineMin) begin
            state_next.fine_code = state_cur.fine_code - 1'b1;
         end else if (state_cur.coarse_range != dfls_pkg::CoarseMin) begin
            state_next.coarse_range = state_cur.coarse_range - 1'b1;
            state_next.fine_code    = dfls_pkg::FineMax;
         end
      end else if (step_up) begin
         if (state_cur.fine_code != dfls_pkg::FineMax) begin
            state_next.fine_code = state_cur.fine_code + 1'b1;
         end else if (state_cur.coarse_range != dfls_pkg::CoarseMax) begin
            state_next.coarse_range = state_cur.coarse_range + 1'b1;
            state_next.fine_code    = dfls_pkg::FineMin;
         end
      end
      if ((step_down || step_up) && (count_base != dfls_pkg::CountMax)) begin
         state_next.adjust_count = count_base + 1'b1;
      end
   end

endmodule

FILE: design/dco_frequency_lock_stepper.sv
// ----------------------------------------------------------------------------
// dco_frequency_lock_stepper
// Frequency-locked-loop calibration step for a digitally controlled
// oscillator: measures, compares with bounds, and nudges the DCO code.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Beat contents
//   req_     in         valid / stall      two timer captures, overflow, start
//   rsp_     out        valid / stall      DCO code, range, lock, count, freq
//   csr_     in         valid / ready      register index, 31-bit bound value
//
// A request beat is taken into an input register, from which the step logic
// loads the result register and the tuning state; a new beat can enter every
// cycle unless a stalled result holds a beat in the input register.
// Beats flagged with a capture overflow leave without a result or state change.
// Reset is synchronous and active high: both registers empty, code 0x60,
// range 4, step count zero, bounds at full span. A stalled result raises
// req_stall only while the input register holds a beat that needs the result
// register. The register port is always ready and takes one write per cycle.
//
module dco_frequency_lock_stepper (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dfls_pkg::CaptureWidth-1:0] req_early_count,
   input  logic [dfls_pkg::CaptureWidth-1:0] req_late_count,
   input  logic                              req_capture_overflow,
   input  logic                              req_start_tune,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dfls_pkg::FineWidth-1:0]    rsp_dco_code,
   output logic [dfls_pkg::CoarseWidth-1:0]  rsp_range_select,
   output logic                              rsp_locked,
   output logic [dfls_pkg::CountWidth-1:0]   rsp_step_count,
   output logic [dfls_pkg::FreqWidth-1:0]    rsp_measured_frequency,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [0:0]                        csr_index,
   input  logic [dfls_pkg::FreqWidth-1:0]    csr_data
);

   // Input register.
   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic [dfls_pkg::CaptureWidth-1:0] first_ff;
   logic [dfls_pkg::CaptureWidth-1:0] second_ff;
   logic                              overflow_ff;
   logic                              start_ff;

   // Tuning state and result register.
   dfls_pkg::tune_state_type          state_ff;
   dfls_pkg::tune_state_type          state_in;
   dfls_pkg::tune_state_type          state_step;
   logic                              out_valid_ff;
   logic                              out_valid_in;
   logic                              locked_ff;
   logic [dfls_pkg::FreqWidth-1:0]    freq_ff;

   dfls_pkg::bounds_type              bounds;
   logic                              step_locked;
   logic [dfls_pkg::FreqWidth-1:0]    step_freq;

   logic                              out_open;
   logic                              in_leave;
   logic                              in_load;
   logic                              out_load;

   assign csr_ready = 1'b1;

   dfls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .bounds    (bounds)
   );

   dfls_step u_step (
      .early_count        (first_ff),
      .late_count         (second_ff),
      .start_tune         (start_ff),
      .bounds             (bounds),
      .state_cur          (state_ff),
      .state_next         (state_step),
      .locked             (step_locked),
      .measured_frequency (step_freq)
   );

   // The result register can take a new beat when empty or being drained.
   assign out_open = !out_valid_ff || !rsp_stall;

   // An overflowed beat never needs the result register, so it always leaves.
   assign in_leave = in_valid_ff && (overflow_ff || out_open);
   assign req_stall = in_valid_ff && !in_leave;
   assign in_load   = req_valid && !req_stall;
   assign out_load  = in_leave && !overflow_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_load) begin
         in_valid_in = 1'b1;
      end else if (in_leave) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end

      state_in = out_load ? state_step : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         state_ff.fine_code     <= dfls_pkg::FineReset;
         state_ff.coarse_range  <= dfls_pkg::CoarseReset;
         state_ff.adjust_count  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (in_load) begin
         first_ff    <= req_early_count;
         second_ff   <= req_late_count;
         overflow_ff <= req_capture_overflow;
         start_ff    <= req_start_tune;
      end
      if (out_load) begin
         locked_ff <= step_locked;
         freq_ff   <= step_freq;
      end
   end

   // The tuning state only changes when a result is loaded, so it doubles
   // as the held copy of the code, range and count for a stalled result.
   assign rsp_valid              = out_valid_ff;
   assign rsp_dco_code           = state_ff.fine_code;
   assign rsp_range_select       = state_ff.coarse_range;
   assign rsp_step_count         = state_ff.adjust_count;
   assign rsp_locked             = locked_ff;
   assign rsp_measured_frequency = freq_ff;

endmodule
